// ===== design/scpd_pkg.sv =====
`timescale 1ns / 1ps
package scpd_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int PAYLOAD_MAX = 16;
  localparam int MIN_FRAME_BYTES = 5;

  localparam int BYTE_W = 8;
  localparam int MSG_SIZE_W = 5;
  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int CMP_W = ((ADDR_W > BYTE_W) ? ADDR_W : BYTE_W) + 1;
  localparam int TDATA_W = ((2 * BYTE_W + MSG_SIZE_W + 7) / 8) * 8;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ADDR_W-1:0] ptr_t;
  typedef logic [ADDR_W:0] ptrx_t;
  typedef logic [CMP_W-1:0] cmp_t;
  typedef logic [MSG_SIZE_W-1:0] msg_size_t;

  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  localparam byte_t START_MARKER_RST = 8'd10;
  localparam msg_size_t MAX_PAYLOAD_RST = 5'd16;

  typedef struct packed {
    logic      found;
    byte_t     msg_id;
    msg_size_t msg_size;
    byte_t     payload_byte;
    logic      last;
  } res_t;

  function automatic ptr_t ptr_add(input ptr_t a, input ptr_t b);
    ptrx_t s;
    s = ptrx_t'(a) + ptrx_t'(b);
    if (s >= ptrx_t'(BUFFER_DEPTH)) begin
      s = s - ptrx_t'(BUFFER_DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

  function automatic ptr_t ptr_dist(input ptr_t a, input ptr_t b);
    ptrx_t s;
    s = ptrx_t'(a) - ptrx_t'(b);
    if (a < b) begin
      s = s + ptrx_t'(BUFFER_DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

// ===== design/scpd_ram.sv =====
`timescale 1ns / 1ps
module scpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/scpd_ctrl.sv =====
`timescale 1ns / 1ps
module scpd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  scpd_pkg::byte_t       in_byte,
  input  scpd_pkg::byte_t       start_marker,
  input  scpd_pkg::msg_size_t   max_payload,
  input  logic                  out_free,
  output logic                  res_load,
  output scpd_pkg::res_t        res,
  output logic                  ram_we,
  output scpd_pkg::ptr_t        ram_waddr,
  output scpd_pkg::byte_t       ram_wdata,
  output scpd_pkg::ptr_t        ram_raddr,
  input  scpd_pkg::byte_t       ram_rdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_ID   = 3'd2;
  localparam logic [2:0] ST_SIZE = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;
  localparam logic [2:0] ST_NONE = 3'd6;

  logic [2:0]            state, state_next;
  scpd_pkg::ptr_t        rd, rd_next;
  scpd_pkg::ptr_t        wr, wr_next;
  scpd_pkg::ptr_t        off, off_next;
  scpd_pkg::byte_t       msg_id, msg_id_next;
  scpd_pkg::byte_t       size, size_next;
  scpd_pkg::byte_t       sum, sum_next;

  scpd_pkg::ptr_t        count;
  scpd_pkg::cmp_t        count_c;
  scpd_pkg::cmp_t        size_c;
  scpd_pkg::cmp_t        off_c;
  scpd_pkg::cmp_t        limit_c;
  scpd_pkg::cmp_t        frame_len;
  logic                  in_accept;
  logic                  last_item;

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign ram_waddr = wr;
  assign ram_wdata = in_byte;

  assign count     = scpd_pkg::ptr_dist(wr, rd);
  assign count_c   = scpd_pkg::cmp_t'(count);
  assign size_c    = scpd_pkg::cmp_t'(size);
  assign off_c     = scpd_pkg::cmp_t'(off);
  assign frame_len = size_c + scpd_pkg::cmp_t'(4);
  assign limit_c   = (scpd_pkg::cmp_t'(max_payload) < scpd_pkg::cmp_t'(scpd_pkg::PAYLOAD_MAX))
                   ? scpd_pkg::cmp_t'(max_payload) : scpd_pkg::cmp_t'(scpd_pkg::PAYLOAD_MAX);
  assign last_item = (size == '0) || (off_c == size_c + scpd_pkg::cmp_t'(2));

  // prefetch: data for (rd, off) arrives in the cycle that holds them
  assign ram_raddr = scpd_pkg::ptr_add(rd_next, off_next);

  always_comb begin
    state_next  = state;
    rd_next     = rd;
    wr_next     = wr;
    off_next    = off;
    msg_id_next = msg_id;
    size_next   = size;
    sum_next    = sum;
    ram_we      = 1'b0;
    res_load    = 1'b0;
    res         = '0;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_kind == scpd_pkg::KIND_POLL) begin
            off_next   = '0;
            state_next = ST_SCAN;
          end else begin
            ram_we  = 1'b1;
            wr_next = scpd_pkg::ptr_add(wr, scpd_pkg::ptr_t'(1));
            if (wr_next == rd) begin
              rd_next = scpd_pkg::ptr_add(rd, scpd_pkg::ptr_t'(1));
            end
          end
        end
      end
      ST_SCAN: begin
        if (off == count) begin
          rd_next    = wr;
          state_next = ST_NONE;
        end else if (ram_rdata == start_marker) begin
          rd_next    = scpd_pkg::ptr_add(rd, off);
          off_next   = scpd_pkg::ptr_t'(1);
          state_next = ST_ID;
        end else begin
          off_next = off + scpd_pkg::ptr_t'(1);
        end
      end
      ST_ID: begin
        if (count_c < scpd_pkg::cmp_t'(scpd_pkg::MIN_FRAME_BYTES)) begin
          state_next = ST_NONE;
        end else begin
          msg_id_next = ram_rdata;
          off_next    = scpd_pkg::ptr_t'(2);
          state_next  = ST_SIZE;
        end
      end
      ST_SIZE: begin
        if (scpd_pkg::cmp_t'(ram_rdata) > limit_c) begin
          rd_next    = scpd_pkg::ptr_add(rd, scpd_pkg::ptr_t'(1));
          state_next = ST_NONE;
        end else if (count_c < scpd_pkg::cmp_t'(ram_rdata) + scpd_pkg::cmp_t'(4)) begin
          state_next = ST_NONE;
        end else begin
          size_next  = ram_rdata;
          sum_next   = msg_id + ram_rdata;
          off_next   = scpd_pkg::ptr_t'(3);
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (off_c == size_c + scpd_pkg::cmp_t'(3)) begin
          if (ram_rdata == sum) begin
            off_next   = scpd_pkg::ptr_t'(3);
            state_next = ST_EMIT;
          end else begin
            rd_next    = scpd_pkg::ptr_add(rd, scpd_pkg::ptr_t'(1));
            state_next = ST_NONE;
          end
        end else begin
          sum_next = sum + ram_rdata;
          off_next = off + scpd_pkg::ptr_t'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          res_load         = 1'b1;
          res.found        = 1'b1;
          res.msg_id       = msg_id;
          res.msg_size     = size[scpd_pkg::MSG_SIZE_W-1:0];
          res.payload_byte = (size == '0) ? '0 : ram_rdata;
          res.last         = last_item;
          if (last_item) begin
            rd_next    = scpd_pkg::ptr_add(rd, frame_len[scpd_pkg::ADDR_W-1:0]);
            off_next   = '0;
            state_next = ST_IDLE;
          end else begin
            off_next = off + scpd_pkg::ptr_t'(1);
          end
        end
      end
      ST_NONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          res.last   = 1'b1;
          off_next   = '0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd    <= '0;
      wr    <= '0;
      off   <= '0;
    end else begin
      state <= state_next;
      rd    <= rd_next;
      wr    <= wr_next;
      off   <= off_next;
    end
  end

  always_ff @(posedge clk) begin
    msg_id <= msg_id_next;
    size   <= size_next;
    sum    <= sum_next;
  end

endmodule

// ===== design/scpd_out.sv =====
`timescale 1ns / 1ps
module scpd_out (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  scpd_pkg::res_t                       res,
  output logic                                 free,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [scpd_pkg::TDATA_W-1:0]         m_tdata,
  output logic                                 m_tuser,
  output logic                                 m_tlast
);

  scpd_pkg::res_t hold;

  assign free     = !m_tvalid || m_tready;
  assign m_tuser  = hold.found;
  assign m_tlast  = hold.last;
  assign m_tdata  = scpd_pkg::TDATA_W'({hold.payload_byte, hold.msg_size, hold.msg_id});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= res;
    end
  end

endmodule

// ===== design/sum_checked_packet_deframer.sv =====
`timescale 1ns / 1ps
// Store item: written to the ring when taken; the input stays ready for the next item.
// Poll item: scans for the start marker, reads msg_id and size, sums and checks the frame,
// then emits its payload items (one item for an empty payload, a not-found item when no
// frame is taken); the input is not ready again until the last result item is loaded.
// Results leave at one item per cycle while the output is not stalled by m_tready.
// Reset (rst, synchronous) clears the ring pointers and output valid and loads
// start_marker = 10, max_payload = 16; ring RAM contents are left as they are.
module sum_checked_packet_deframer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,   // rx_byte
  input  logic                                 s_tuser,   // kind
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [scpd_pkg::TDATA_W-1:0]         m_tdata,   // msg_id, msg_size, payload_byte
  output logic                                 m_tuser,   // found
  output logic                                 m_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [7:0]                           cfg_data
);

  scpd_pkg::byte_t     start_marker;
  scpd_pkg::msg_size_t max_payload;

  logic                out_free;
  logic                res_load;
  scpd_pkg::res_t      res;
  logic                ram_we;
  scpd_pkg::ptr_t      ram_waddr;
  scpd_pkg::byte_t     ram_wdata;
  scpd_pkg::ptr_t      ram_raddr;
  scpd_pkg::byte_t     ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= scpd_pkg::START_MARKER_RST;
      max_payload  <= scpd_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        scpd_pkg::REG_START_MARKER: start_marker <= cfg_data;
        scpd_pkg::REG_MAX_PAYLOAD:  max_payload  <= cfg_data[scpd_pkg::MSG_SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  scpd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_kind      (s_tuser),
    .in_byte      (s_tdata),
    .start_marker (start_marker),
    .max_payload  (max_payload),
    .out_free     (out_free),
    .res_load     (res_load),
    .res          (res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  scpd_ram #(
    .WIDTH (scpd_pkg::BYTE_W),
    .DEPTH (scpd_pkg::BUFFER_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  scpd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_load),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== tb/sum_checked_packet_deframer_checker.sv =====
`timescale 1ns / 1ps
module sum_checked_packet_deframer_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // rx_byte
  input  logic                         s_tuser,   // kind
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [scpd_pkg::TDATA_W-1:0] m_tdata,   // msg_id, msg_size, payload_byte
  input  logic                         m_tuser,   // found
  input  logic                         m_tlast,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [7:0]                   cfg_data,
  output int                           errors,
  output int                           pending
);

  localparam int ID_LSB = 0;
  localparam int SIZE_LSB = scpd_pkg::BYTE_W;
  localparam int DATA_LSB = scpd_pkg::BYTE_W + scpd_pkg::MSG_SIZE_W;

  scpd_pkg::byte_t     ring_copy [scpd_pkg::BUFFER_DEPTH];
  int                  wr_pos;
  int                  rd_pos;
  scpd_pkg::byte_t     marker;
  scpd_pkg::msg_size_t max_len;
  int                  fail_count = 0;
  scpd_pkg::res_t      payload_due [$];

  function automatic int held_bytes();
    return (wr_pos + scpd_pkg::BUFFER_DEPTH - rd_pos) % scpd_pkg::BUFFER_DEPTH;
  endfunction

  function automatic scpd_pkg::byte_t peek_byte(int off);
    return ring_copy[(rd_pos + off) % scpd_pkg::BUFFER_DEPTH];
  endfunction

  function automatic void drop_bytes(int n);
    int c;
    c = held_bytes();
    if (n > c) n = c;
    rd_pos = (rd_pos + n) % scpd_pkg::BUFFER_DEPTH;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic store_byte(scpd_pkg::byte_t b);
    ring_copy[wr_pos] = b;
    wr_pos = (wr_pos + 1) % scpd_pkg::BUFFER_DEPTH;
    if (wr_pos == rd_pos) rd_pos = (rd_pos + 1) % scpd_pkg::BUFFER_DEPTH;
  endtask

  task automatic extract_frame();
    int              cnt;
    int              i;
    int              lim;
    int              sz;
    scpd_pkg::byte_t id;
    scpd_pkg::byte_t sum;
    cnt = held_bytes();
    i = 0;
    while (i < cnt && peek_byte(i) != marker) i++;
    drop_bytes(i);
    cnt = held_bytes();
    if (cnt >= scpd_pkg::MIN_FRAME_BYTES) begin
      lim = (max_len < scpd_pkg::PAYLOAD_MAX) ? int'(max_len) : scpd_pkg::PAYLOAD_MAX;
      id = peek_byte(1);
      sz = peek_byte(2);
      if (sz > lim) begin
        drop_bytes(1);
      end else if (cnt >= sz + 4) begin
        sum = '0;
        for (i = 0; i < sz + 2; i++) sum = sum + peek_byte(i + 1);
        if (sum == peek_byte(sz + 3)) begin
          if (sz == 0) begin
            payload_due.push_back('{found: 1'b1, msg_id: id, msg_size: '0,
                                    payload_byte: '0, last: 1'b1});
            drop_bytes(4);
            return;
          end
          for (i = 0; i < sz; i++) begin
            payload_due.push_back('{found: 1'b1, msg_id: id,
                                    msg_size: scpd_pkg::msg_size_t'(sz),
                                    payload_byte: peek_byte(i + 3),
                                    last: (i + 1 == sz)});
          end
          drop_bytes(sz + 4);
          return;
        end
        drop_bytes(1);
      end
    end
    payload_due.push_back('{found: 1'b0, msg_id: '0, msg_size: '0,
                            payload_byte: '0, last: 1'b1});
  endtask

  task automatic check_result();
    scpd_pkg::res_t want;
    if (payload_due.size() == 0) begin
      report_mismatch("unexpected result item, payload_byte",
                      m_tdata[DATA_LSB +: scpd_pkg::BYTE_W], -1);
      return;
    end
    want = payload_due.pop_front();
    if (m_tuser !== want.found) report_mismatch("found", m_tuser, want.found);
    if (m_tdata[ID_LSB +: scpd_pkg::BYTE_W] !== want.msg_id)
      report_mismatch("msg_id", m_tdata[ID_LSB +: scpd_pkg::BYTE_W], want.msg_id);
    if (m_tdata[SIZE_LSB +: scpd_pkg::MSG_SIZE_W] !== want.msg_size)
      report_mismatch("msg_size", m_tdata[SIZE_LSB +: scpd_pkg::MSG_SIZE_W], want.msg_size);
    if (m_tdata[DATA_LSB +: scpd_pkg::BYTE_W] !== want.payload_byte)
      report_mismatch("payload_byte", m_tdata[DATA_LSB +: scpd_pkg::BYTE_W],
                      want.payload_byte);
    if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      wr_pos = 0;
      rd_pos = 0;
      marker = scpd_pkg::START_MARKER_RST;
      max_len = scpd_pkg::MAX_PAYLOAD_RST;
      payload_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == scpd_pkg::REG_START_MARKER) marker = cfg_data;
        else max_len = cfg_data[scpd_pkg::MSG_SIZE_W-1:0];
      end
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) begin
        if (s_tuser == scpd_pkg::KIND_STORE) store_byte(s_tdata);
        else extract_frame();
      end
    end
    errors <= fail_count;
    pending <= payload_due.size();
  end

endmodule

// ===== tb/sum_checked_packet_deframer_tb.sv =====
`timescale 1ns / 1ps
module sum_checked_packet_deframer_tb;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = scpd_pkg::BUFFER_DEPTH + scpd_pkg::PAYLOAD_MAX + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 55;

  typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_CUT, FRAME_OVERSIZE} flaw_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [7:0]                   s_tdata = '0;
  logic                         s_tuser = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [scpd_pkg::TDATA_W-1:0] m_tdata;
  logic                         m_tuser;
  logic                         m_tlast;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic                         cfg_index = 1'b0;
  logic [7:0]                   cfg_data = '0;

  int              errors;
  int              pending;
  bit              idle_on = 1'b1;
  bit              hold_req = 1'b0;
  int              items_sent = 0;
  int              quiet_cycles = 0;
  scpd_pkg::byte_t marker = scpd_pkg::START_MARKER_RST;
  int              limit_now = scpd_pkg::PAYLOAD_MAX;

  sum_checked_packet_deframer dut (.*);
  sum_checked_packet_deframer_checker checker_i (.*);

  always #2 clk = ~clk;

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 7);
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic k, input scpd_pkg::byte_t b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input scpd_pkg::byte_t b);
    send_item(scpd_pkg::KIND_STORE, b);
  endtask

  task automatic send_poll();
    send_item(scpd_pkg::KIND_POLL, scpd_pkg::byte_t'($urandom));
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_byte(scpd_pkg::byte_t'($urandom));
  endtask

  task automatic send_frame(input int sz, input flaw_t flaw);
    scpd_pkg::byte_t fb [$];
    scpd_pkg::byte_t id;
    scpd_pkg::byte_t sum;
    scpd_pkg::byte_t d;
    int              k;
    int              cut;
    id = scpd_pkg::byte_t'($urandom);
    fb.push_back(marker);
    fb.push_back(id);
    if (flaw == FRAME_OVERSIZE) begin
      if ($urandom_range(0, 1) == 1) fb.push_back(scpd_pkg::byte_t'(limit_now + 1));
      else fb.push_back(scpd_pkg::byte_t'($urandom_range(limit_now + 1, 255)));
      repeat ($urandom_range(2, 4)) fb.push_back(scpd_pkg::byte_t'($urandom));
      cut = fb.size();
    end else begin
      fb.push_back(scpd_pkg::byte_t'(sz));
      sum = id + scpd_pkg::byte_t'(sz);
      for (k = 0; k < sz; k++) begin
        d = scpd_pkg::byte_t'($urandom);
        sum = sum + d;
        fb.push_back(d);
      end
      if (flaw == FRAME_BAD_SUM) sum = sum + scpd_pkg::byte_t'($urandom_range(1, 255));
      fb.push_back(sum);
      cut = (flaw == FRAME_CUT) ? $urandom_range(1, sz + 3) : sz + 4;
    end
    for (k = 0; k < cut; k++) send_byte(fb[k]);
  endtask

  function automatic int pick_size();
    if ($urandom_range(0, 7) == 0) return limit_now;
    return $urandom_range(0, (limit_now < 4) ? limit_now : 4);
  endfunction

  task automatic write_reg(input logic idx, input scpd_pkg::byte_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input scpd_pkg::byte_t m, input scpd_pkg::byte_t p);
    settle();
    write_reg(scpd_pkg::REG_START_MARKER, m);
    write_reg(scpd_pkg::REG_MAX_PAYLOAD, p);
    cfg_valid <= 1'b0;
    marker = m;
    limit_now = (p[scpd_pkg::MSG_SIZE_W-1:0] < scpd_pkg::PAYLOAD_MAX)
              ? int'(p[scpd_pkg::MSG_SIZE_W-1:0]) : scpd_pkg::PAYLOAD_MAX;
  endtask

  task automatic random_sequence();
    int pick;
    int polls;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 1) send_noise($urandom_range(1, 3));
    if (pick < 62) send_frame(pick_size(), FRAME_GOOD);
    else if (pick < 72) send_frame(pick_size(), FRAME_BAD_SUM);
    else if (pick < 82) send_frame(pick_size(), FRAME_CUT);
    else if (pick < 92) send_frame(0, FRAME_OVERSIZE);
    else if (pick < 94) send_noise($urandom_range(60, 75));
    polls = $urandom_range(0, 9);
    if (polls != 0) send_poll();
    if (polls == 9) send_poll();
  endtask

  task automatic random_traffic(input int n);
    int goal;
    goal = items_sent + n;
    while (items_sent < goal) random_sequence();
  endtask

  initial begin : stimulus
    while (rst) @(posedge clk);

    send_poll();
    // zero-length frame, one pad byte so that five bytes are held
    send_byte(8'h0A); send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFF); send_byte(8'h00);
    send_poll();
    // size field one above the limit
    send_byte(8'h0A); send_byte(8'h00); send_byte(8'h11); send_byte(8'hFF); send_byte(8'hFF);
    send_poll();
    // wrong checksum (0x00 where the sum is 0xAC)
    send_byte(8'h0A); send_byte(8'h01); send_byte(8'h01); send_byte(8'hAA); send_byte(8'h00);
    send_poll();
    // incomplete frame, then the rest of it
    send_byte(8'h0A); send_byte(8'h07); send_byte(8'h03); send_byte(8'h01); send_byte(8'h02);
    send_poll();
    send_byte(8'h80); send_byte(8'h8D);
    send_poll();

    set_config(8'h00, 8'd0);
    random_traffic(PHASE_ITEMS);

    set_config(8'hFF, 8'd31);
    send_noise(70);
    send_frame(limit_now, FRAME_GOOD);
    send_poll();
    random_traffic(PHASE_ITEMS);

    set_config(scpd_pkg::byte_t'($urandom), 8'd16);
    hold_req = 1'b1;
    repeat (8) begin
      send_frame(pick_size(), FRAME_GOOD);
      send_poll();
    end
    random_traffic(PHASE_ITEMS);

    set_config(scpd_pkg::byte_t'($urandom), {3'($urandom), 5'($urandom_range(1, 31))});
    random_traffic(PHASE_ITEMS);

    set_config(scpd_pkg::START_MARKER_RST, 8'(scpd_pkg::MAX_PAYLOAD_RST));
    idle_on = 1'b0;
    random_traffic(PHASE_ITEMS);

    settle();
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sum_checked_packet_deframer.f =====
design/scpd_pkg.sv
design/scpd_ram.sv
design/scpd_ctrl.sv
design/scpd_out.sv
design/sum_checked_packet_deframer.sv
tb/sum_checked_packet_deframer_checker.sv
tb/sum_checked_packet_deframer_tb.sv
